FILE: hw/rtl/tfl_pkg.sv
// ---------------------------------------------------------------------------
// tfl_pkg: shared definitions for the tiered free-list slot allocator
// Sizes, status and opcode enums, sequencer states and request structs.
// ---------------------------------------------------------------------------
`default_nettype none

package tfl_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int TIERS     = 4;
    localparam int TIER_W    = 2;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W    = TIER_W + SLOT_W;
    localparam int SCALE_W   = 12;
    localparam int STATUS_W  = 3;

    // input tdata: scale_q8, release_tier, release_slot
    localparam int IN_USED_W = SCALE_W + TIER_W + 6;
    localparam int IN_W      = ((IN_USED_W + 7) / 8) * 8;

    // output tdata: status, tier, slot, used_count, capacity
    localparam int OUT_USED_W = STATUS_W + TIER_W + SLOT_W + 2 * CNT_W;
    localparam int OUT_W      = ((OUT_USED_W + 7) / 8) * 8;

    // tier thresholds in Q4.8
    localparam logic [SCALE_W-1:0] SCALE_T0 = 12'd64;
    localparam logic [SCALE_W-1:0] SCALE_T1 = 12'd128;
    localparam logic [SCALE_W-1:0] SCALE_T2 = 12'd256;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DISABLED = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FREE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ALU_INC_SAT,
        ALU_DEC_SAT,
        ALU_DBL_SAT,
        ALU_LT
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GROW,
        S_POP,
        S_POPW,
        S_REL_PUSH,
        S_REL_CNT,
        S_DONE
    } state_t;

    typedef struct packed {
        alu_op_t          op;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [SLOT_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } stk_req_t;

    // scale to tier mapping
    function automatic logic [TIER_W-1:0] pick_tier(input logic [SCALE_W-1:0] scale);
        logic [TIER_W-1:0] t;
        if (scale <= SCALE_T0) begin
            t = 2'd0;
        end else if (scale <= SCALE_T1) begin
            t = 2'd1;
        end else if (scale <= SCALE_T2) begin
            t = 2'd2;
        end else begin
            t = 2'd3;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tfl_stack_mem.sv
// ---------------------------------------------------------------------------
// tfl_stack_mem: free-index stack storage
// One write and one registered read port; all tiers share the array,
// addressed by {tier, stack position}.
// ---------------------------------------------------------------------------
`default_nettype none

module tfl_stack_mem
    import tfl_pkg::*;
(
    input  wire logic              aclk,
    input  wire stk_req_t          req,
    output logic     [SLOT_W-1:0]  rd_data
);

    logic [SLOT_W-1:0] mem [TIERS*MAX_SLOTS];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tfl_alu.sv
// ---------------------------------------------------------------------------
// tfl_alu: shared count/capacity unit
// Saturating increment, decrement and doubling, plus less-than compare.
// ---------------------------------------------------------------------------
`default_nettype none

module tfl_alu
    import tfl_pkg::*;
(
    input  wire alu_req_t        req,
    output logic     [CNT_W-1:0] res,
    output logic                 lt
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

    logic [CNT_W:0] dbl;

    assign dbl = {req.a, 1'b0};
    assign lt  = (req.a < req.b);

    always_comb begin
        unique case (req.op)
            ALU_INC_SAT: res = (req.a >= MAX_CNT) ? req.a : req.a + CNT_W'(1);
            ALU_DEC_SAT: res = (req.a == '0) ? '0 : req.a - CNT_W'(1);
            ALU_DBL_SAT: begin
                // 0 grows to 1, otherwise double and clamp
                if (req.a == '0) begin
                    res = CNT_W'(1);
                end else if (dbl > {1'b0, MAX_CNT}) begin
                    res = MAX_CNT;
                end else begin
                    res = dbl[CNT_W-1:0];
                end
            end
            ALU_LT:      res = req.a;
            default:     res = req.a;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tiered_free_list_slot_allocator_unit.sv
// Sequence: an alloc from a non-empty stack runs S_CHECK, S_POP, S_POPW and S_DONE;
//   a good release runs S_CHECK, S_REL_PUSH, S_REL_CNT and S_DONE; disabled, full,
//   range and free-slot errors go from S_CHECK to S_DONE. An alloc that grows its
//   tier runs S_GROW before S_POP, pushing one index per cycle into the stack RAM.
// Throughput: one item at a time; the next input is taken when the result is registered.
// Reset: aresetn synchronous active low; clears counts, capacities and enable;
//   allocated flags of a tier are cleared as the tier grows.
// ---------------------------------------------------------------------------
// tiered_free_list_slot_allocator_unit: four-tier slot allocator
// Per-tier LIFO free stacks in one RAM, allocated flags, counts and
// capacities, driven by a sequencer around one shared count unit.
// ---------------------------------------------------------------------------
`default_nettype none

module tiered_free_list_slot_allocator_unit
    import tfl_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data,

    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] scale_q8, [13:12] release_tier, [19:14] release_slot, rest zero
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    // [0] func
    input  wire logic [0:0]       s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // [2:0] status, [4:3] tier, [10:5] slot, [17:11] used_count,
    // [24:18] capacity, rest zero
    output logic [OUT_W-1:0]      m_axis_tdata
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

    state_t                  state_reg, state_next;
    logic                    enable_reg;
    logic                    func_reg, func_next;
    logic [TIER_W-1:0]       tier_reg, tier_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    status_t                 status_reg, status_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        grow_cap_reg, grow_cap_next;

    logic [CNT_W-1:0]        depth_reg [TIERS];
    logic [CNT_W-1:0]        depth_next [TIERS];
    logic [CNT_W-1:0]        used_reg [TIERS];
    logic [CNT_W-1:0]        used_next [TIERS];
    logic [CNT_W-1:0]        cap_reg [TIERS];
    logic [CNT_W-1:0]        cap_next [TIERS];

    // allocated flags, one per {tier, slot}
    logic                    taken_mem [TIERS*MAX_SLOTS];
    logic                    taken_rd_reg;
    logic                    taken_wr_en;
    logic [ADDR_W-1:0]       taken_wr_addr;
    logic                    taken_wr_data;
    logic                    taken_rd_en;
    logic [ADDR_W-1:0]       taken_rd_addr;

    logic                    m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]        m_data_reg, m_data_next;

    alu_req_t                alu_req;
    logic [CNT_W-1:0]        alu_res;
    logic                    alu_lt;
    stk_req_t                stk_req;
    logic [SLOT_W-1:0]       stk_rd_data;

    tfl_alu u_alu (
        .req (alu_req),
        .res (alu_res),
        .lt  (alu_lt)
    );

    tfl_stack_mem u_stack (
        .aclk    (aclk),
        .req     (stk_req),
        .rd_data (stk_rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            enable_reg <= cfg_wr_data;
        end
    end

    // flag store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (taken_wr_en) begin
            taken_mem[taken_wr_addr] <= taken_wr_data;
        end
        if (taken_rd_en) begin
            taken_rd_reg <= taken_mem[taken_rd_addr];
        end
    end

    // control state and per-tier bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < TIERS; i++) begin
                depth_reg[i] <= '0;
                used_reg[i]  <= '0;
                cap_reg[i]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < TIERS; i++) begin
                depth_reg[i] <= depth_next[i];
                used_reg[i]  <= used_next[i];
                cap_reg[i]   <= cap_next[i];
            end
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        tier_reg     <= tier_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        cnt_reg      <= cnt_next;
        grow_cap_reg <= grow_cap_next;
        m_data_reg   <= m_data_next;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        tier_next     = tier_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;
        cnt_next      = cnt_reg;
        grow_cap_next = grow_cap_reg;
        for (int i = 0; i < TIERS; i++) begin
            depth_next[i] = depth_reg[i];
            used_next[i]  = used_reg[i];
            cap_next[i]   = cap_reg[i];
        end
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        alu_req       = '{op: ALU_LT, a: '0, b: '0};
        stk_req       = '0;
        taken_wr_en   = 1'b0;
        taken_wr_addr = '0;
        taken_wr_data = 1'b0;
        taken_rd_en   = 1'b0;
        taken_rd_addr = {s_axis_tdata[SCALE_W +: TIER_W],
                         s_axis_tdata[SCALE_W+TIER_W +: SLOT_W]};

        unique case (state_reg)
            S_IDLE: begin
                // flag of the release handle is read on the input transfer
                taken_rd_en = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    func_next = s_axis_tuser[0];
                    if (s_axis_tuser[0] == FUNC_ALLOC) begin
                        tier_next = pick_tier(s_axis_tdata[SCALE_W-1:0]);
                        slot_next = '0;
                    end else begin
                        tier_next = s_axis_tdata[SCALE_W +: TIER_W];
                        slot_next = s_axis_tdata[SCALE_W+TIER_W +: SLOT_W];
                    end
                    state_next = S_CHECK;
                end
            end

            S_CHECK: begin
                if (func_reg == FUNC_ALLOC) begin
                    alu_req = '{op: ALU_DBL_SAT, a: cap_reg[tier_reg], b: '0};
                    if (!enable_reg) begin
                        status_next = ST_DISABLED;
                        state_next  = S_DONE;
                    end else if (depth_reg[tier_reg] == '0) begin
                        // empty stack: grow unless already at the ceiling
                        if (alu_res == cap_reg[tier_reg]) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            grow_cap_next = alu_res;
                            cnt_next      = alu_res;
                            state_next    = S_GROW;
                        end
                    end else begin
                        state_next = S_POP;
                    end
                end else begin
                    alu_req = '{op: ALU_LT, a: CNT_W'(slot_reg), b: cap_reg[tier_reg]};
                    if (!alu_lt) begin
                        status_next = ST_RANGE;
                        state_next  = S_DONE;
                    end else if (!taken_rd_reg) begin
                        status_next = ST_FREE;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_REL_PUSH;
                    end
                end
            end

            S_GROW: begin
                // push new indices from highest down to the old capacity
                alu_req = '{op: ALU_DEC_SAT, a: cnt_reg, b: '0};
                if (depth_reg[tier_reg] != MAX_CNT) begin
                    stk_req.wr_en   = 1'b1;
                    stk_req.wr_addr = {tier_reg, depth_reg[tier_reg][SLOT_W-1:0]};
                    stk_req.wr_data = alu_res[SLOT_W-1:0];
                    depth_next[tier_reg] = depth_reg[tier_reg] + CNT_W'(1);
                end
                taken_wr_en   = 1'b1;
                taken_wr_addr = {tier_reg, alu_res[SLOT_W-1:0]};
                taken_wr_data = 1'b0;
                cnt_next = alu_res;
                if (alu_res == cap_reg[tier_reg]) begin
                    cap_next[tier_reg] = grow_cap_reg;
                    state_next         = S_POP;
                end
            end

            S_POP: begin
                alu_req = '{op: ALU_DEC_SAT, a: depth_reg[tier_reg], b: '0};
                depth_next[tier_reg] = alu_res;
                stk_req.rd_en   = 1'b1;
                stk_req.rd_addr = {tier_reg, alu_res[SLOT_W-1:0]};
                state_next      = S_POPW;
            end

            S_POPW: begin
                alu_req = '{op: ALU_INC_SAT, a: used_reg[tier_reg], b: '0};
                used_next[tier_reg] = alu_res;
                slot_next     = stk_rd_data;
                taken_wr_en   = 1'b1;
                taken_wr_addr = {tier_reg, stk_rd_data};
                taken_wr_data = 1'b1;
                status_next   = ST_OK;
                state_next    = S_DONE;
            end

            S_REL_PUSH: begin
                // a push onto a full stack is dropped
                alu_req = '{op: ALU_INC_SAT, a: depth_reg[tier_reg], b: '0};
                if (alu_res != depth_reg[tier_reg]) begin
                    stk_req.wr_en   = 1'b1;
                    stk_req.wr_addr = {tier_reg, depth_reg[tier_reg][SLOT_W-1:0]};
                    stk_req.wr_data = slot_reg;
                    depth_next[tier_reg] = alu_res;
                end
                taken_wr_en   = 1'b1;
                taken_wr_addr = {tier_reg, slot_reg};
                taken_wr_data = 1'b0;
                state_next    = S_REL_CNT;
            end

            S_REL_CNT: begin
                alu_req = '{op: ALU_DEC_SAT, a: used_reg[tier_reg], b: '0};
                used_next[tier_reg] = alu_res;
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            S_DONE: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({cap_reg[tier_reg], used_reg[tier_reg],
                                           slot_reg, tier_reg, status_reg});
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tfl_checker.sv
// ---------------------------------------------------------------------------
// tfl_checker: port-level checks for the slot allocator
// Watches the stream ports and the result fields over time.
// ---------------------------------------------------------------------------
`default_nettype none

module tfl_checker
    import tfl_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    localparam int SLOT_LSB = STATUS_W + TIER_W;
    localparam int USED_LSB = SLOT_LSB + SLOT_W;
    localparam int CAP_LSB  = USED_LSB + CNT_W;

    logic [STATUS_W-1:0] out_status;
    logic [SLOT_W-1:0]   out_slot;
    logic [CNT_W-1:0]    out_used;
    logic [CNT_W-1:0]    out_cap;

    assign out_status = m_axis_tdata[STATUS_W-1:0];
    assign out_slot   = m_axis_tdata[SLOT_LSB +: SLOT_W];
    assign out_used   = m_axis_tdata[USED_LSB +: CNT_W];
    assign out_cap    = m_axis_tdata[CAP_LSB +: CNT_W];

    // one item at a time: input closes right after a transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an input transfer");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

    // allocated count never exceeds the capacity, capacity bounded
    a_used_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((out_used <= out_cap) && (out_cap <= CNT_W'(MAX_SLOTS))))
        else $error("used count above capacity");

    // refused allocations report slot zero
    a_refused_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (out_status == ST_DISABLED || out_status == ST_FULL))
        |-> (out_slot == '0))
        else $error("refused allocation with nonzero slot");

endmodule

bind tiered_free_list_slot_allocator_unit tfl_checker u_tfl_checker (.*);

`default_nettype wire
